FILE: sv/dapc_pkg.sv
// ----------------------------------------------------------------------------
// dapc_pkg
// Shared types, codes and capability tables of the driver access policy checker
// ----------------------------------------------------------------------------
package dapc_pkg;

	localparam logic [1:0] CMD_REGISTER = 2'd0;
	localparam logic [1:0] CMD_CHECK    = 2'd1;
	localparam logic [1:0] CMD_QUERY    = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_DENIED = 2'd1;
	localparam logic [1:0] ST_RANGE  = 2'd2;

	localparam logic [7:0] KIND_MMIO = 8'd1;
	localparam logic [7:0] KIND_IRQ  = 8'd2;
	localparam logic [7:0] KIND_DMA  = 8'd3;

	localparam logic [6:0] CAP_OBS = 7'h01;
	localparam logic [6:0] CAP_CTL = 7'h02;
	localparam logic [6:0] CAP_INT = 7'h04;
	localparam logic [6:0] CAP_DMA = 7'h08;
	localparam logic [6:0] CAP_PWR = 7'h10;
	localparam logic [6:0] CAP_FW  = 7'h20;
	localparam logic [6:0] CAP_ALL = 7'h7F;

	localparam logic [8:0] COUNT_MAX = 9'h1FF;

	typedef logic [6:0] caps_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  slot_id;
		logic [7:0]  access_kind;
		logic [63:0] address;
		logic [15:0] required_caps;
		logic [15:0] device_class_major;
		logic [15:0] claimed_caps;
		logic [63:0] win_base;
		logic [63:0] win_size;
		logic [31:0] irq_number;
	} request_t;

	typedef struct packed {
		caps_t       caps;
		logic        mmio_present;
		logic [63:0] mmio_low;
		logic [63:0] mmio_high;
		logic        irq_present;
		logic [31:0] irq_line;
		logic        dma_present;
	} policy_t;

	typedef struct packed {
		logic [63:0] viol;
		logic [63:0] chk;
	} counters_t;

	typedef struct packed {
		logic       policy_we;
		logic       counters_we;
		logic       count_inc;
		logic [1:0] status;
	} verdict_t;

	function automatic caps_t class_defaults(input logic [15:0] major);
		caps_t c;
		unique case (major)
			16'd1: c = CAP_OBS | CAP_CTL | CAP_DMA | CAP_FW;
			16'd2, 16'd3, 16'd5: c = CAP_OBS | CAP_CTL | CAP_INT | CAP_DMA;
			16'd4: c = CAP_OBS | CAP_CTL | CAP_INT | CAP_DMA | CAP_PWR;
			16'd6: c = CAP_OBS | CAP_INT;
			16'd7: c = CAP_OBS | CAP_CTL;
			16'd8: c = CAP_OBS | CAP_PWR;
			default: c = CAP_OBS;
		endcase
		return c;
	endfunction

	// clip mask chosen by the highest declared capability bit
	function automatic caps_t closure(input logic [6:0] declared);
		caps_t c;
		priority if (declared[6]) c = CAP_ALL;
		else if (declared[5]) c = CAP_OBS | CAP_CTL | CAP_INT | CAP_DMA | CAP_PWR | CAP_FW;
		else if (declared[4]) c = CAP_OBS | CAP_CTL | CAP_INT | CAP_DMA | CAP_PWR;
		else if (declared[3]) c = CAP_OBS | CAP_CTL | CAP_DMA;
		else if (declared[2]) c = CAP_OBS | CAP_CTL | CAP_INT;
		else if (declared[1]) c = CAP_OBS | CAP_CTL;
		else if (declared[0]) c = CAP_OBS;
		else c = '0;
		return c;
	endfunction

endpackage

FILE: sv/dapc_req_if.sv
// ----------------------------------------------------------------------------
// dapc_req_if
// Request channel: valid/ready handshake with the command beat payload
// ----------------------------------------------------------------------------
interface dapc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [7:0]  slot_id;
	logic [7:0]  access_kind;
	logic [63:0] address;
	logic [15:0] required_caps;
	logic [15:0] device_class_major;
	logic [15:0] claimed_caps;
	logic [63:0] win_base;
	logic [63:0] win_size;
	logic [31:0] irq_number;

	modport source (
		output valid, command, slot_id, access_kind, address, required_caps,
		       device_class_major, claimed_caps, win_base, win_size, irq_number,
		input  ready
	);

	modport sink (
		input  valid, command, slot_id, access_kind, address, required_caps,
		       device_class_major, claimed_caps, win_base, win_size, irq_number,
		output ready
	);
endinterface

FILE: sv/dapc_rsp_if.sv
// ----------------------------------------------------------------------------
// dapc_rsp_if
// Response channel: valid/ready handshake with status and counter totals
// ----------------------------------------------------------------------------
interface dapc_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [63:0] violation_total;
	logic [63:0] check_total;

	modport source (
		output valid, status, violation_total, check_total,
		input  ready
	);

	modport sink (
		input  valid, status, violation_total, check_total,
		output ready
	);
endinterface

FILE: sv/driver_access_policy_checker_core.sv
// ----------------------------------------------------------------------------
// driver_access_policy_checker_core
// Per-driver permission table with register, check and counter query commands
// ----------------------------------------------------------------------------
// In the cycle a request beat is accepted, the driver's policy and counter
// entries are read from two RAMs with registered read data. Once the response
// register is free or being emptied, the entry is judged, the RAMs are written
// back and the response beat is loaded into the output register. A new request
// is taken in the cycle after that, also while the previous response still
// waits to be taken; a stalled response holds the request in flight. All
// entries read as zero until their slot is first written, tracked by one valid
// flop per slot, so no clearing pass follows reset.
module driver_access_policy_checker_core #(
	parameter int DRIVER_SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	dapc_req_if.sink    req,
	dapc_rsp_if.source  rsp
);
	import dapc_pkg::*;

	localparam int AW = (DRIVER_SLOTS > 1) ? $clog2(DRIVER_SLOTS) : 1;

	request_t          in_req;
	request_t          req_s1;
	logic              s1_valid_q;
	logic              vld_s1;
	logic [DRIVER_SLOTS-1:0] vld_q;
	logic [8:0]        count_q;
	logic              accept;
	logic              done;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	policy_t           pol_rd;
	policy_t           pol_wr;
	policy_t           pol_wdata;
	counters_t         cnt_rd;
	counters_t         cnt_wr;
	verdict_t          verdict;
	logic [63:0]       viol_total;
	logic [63:0]       chk_total;
	logic              pol_we;
	logic              cnt_we;
	logic              rsp_valid_q;
	logic [1:0]        status_q;
	logic [63:0]       viol_q;
	logic [63:0]       chk_q;

	assign in_req = '{
		command:            req.command,
		slot_id:            req.slot_id,
		access_kind:        req.access_kind,
		address:            req.address,
		required_caps:      req.required_caps,
		device_class_major: req.device_class_major,
		claimed_caps:       req.claimed_caps,
		win_base:           req.win_base,
		win_size:           req.win_size,
		irq_number:         req.irq_number
	};

	assign req.ready = !s1_valid_q;
	assign accept    = req.valid && req.ready;
	assign done      = s1_valid_q && (!rsp_valid_q || rsp.ready);

	// hold the read address while a beat is in flight
	assign rd_addr = accept ? in_req.slot_id[AW-1:0] : req_s1.slot_id[AW-1:0];
	assign wr_addr = req_s1.slot_id[AW-1:0];
	// a counter update on a never written slot also zeroes its policy entry
	assign pol_we    = done && (verdict.policy_we || (verdict.counters_we && !vld_s1));
	assign pol_wdata = verdict.policy_we ? pol_wr : '0;
	assign cnt_we    = done && verdict.counters_we;

	dapc_ram #(
		.WIDTH ($bits(policy_t)),
		.DEPTH (DRIVER_SLOTS)
	) u_policy_ram (
		.clk     (clk),
		.we      (pol_we),
		.wr_addr (wr_addr),
		.wr_data (pol_wdata),
		.rd_addr (rd_addr),
		.rd_data (pol_rd)
	);

	dapc_ram #(
		.WIDTH ($bits(counters_t)),
		.DEPTH (DRIVER_SLOTS)
	) u_counter_ram (
		.clk     (clk),
		.we      (cnt_we),
		.wr_addr (wr_addr),
		.wr_data (cnt_wr),
		.rd_addr (rd_addr),
		.rd_data (cnt_rd)
	);

	dapc_eval #(
		.DRIVER_SLOTS (DRIVER_SLOTS)
	) u_eval (
		.req             (req_s1),
		.count           (count_q),
		.entry_valid     (vld_s1),
		.pol_rd          (pol_rd),
		.cnt_rd          (cnt_rd),
		.verdict         (verdict),
		.pol_wr          (pol_wr),
		.cnt_wr          (cnt_wr),
		.violation_total (viol_total),
		.check_total     (chk_total)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
			count_q     <= 9'd0;
			vld_q       <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (done) begin
				s1_valid_q <= 1'b0;
			end
			if (done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (done && verdict.count_inc && (count_q != COUNT_MAX)) begin
				count_q <= count_q + 9'd1;
			end
			if (pol_we) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= in_req;
			vld_s1 <= vld_q[in_req.slot_id[AW-1:0]];
		end
		if (done) begin
			status_q <= verdict.status;
			viol_q   <= viol_total;
			chk_q    <= chk_total;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = status_q;
	assign rsp.violation_total = viol_q;
	assign rsp.check_total     = chk_q;

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + 9'd1))
		else $error("registered count moved by other than one");

	a_range_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(done && verdict.status == ST_RANGE) |-> (!verdict.policy_we && !verdict.counters_we))
		else $error("out of range slot wrote state");

	a_rsp_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(s1_valid_q))
		else $error("response beat without a request in flight");

	a_register_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(done && verdict.policy_we) |-> (cnt_we && cnt_wr == '0))
		else $error("register did not clear the counters");

endmodule

FILE: sv/dapc_ram.sv
// ----------------------------------------------------------------------------
// dapc_ram
// Generic single write port, single read port RAM with registered read data
// ----------------------------------------------------------------------------
module dapc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: sv/dapc_eval.sv
// ----------------------------------------------------------------------------
// dapc_eval
// Command evaluation: builds a new policy entry on register, judges checks,
// and updates or reports the per-driver counters
// ----------------------------------------------------------------------------
module dapc_eval #(
	parameter int DRIVER_SLOTS = 64
) (
	input  dapc_pkg::request_t  req,
	input  logic [8:0]          count,
	input  logic                entry_valid,
	input  dapc_pkg::policy_t   pol_rd,
	input  dapc_pkg::counters_t cnt_rd,
	output dapc_pkg::verdict_t  verdict,
	output dapc_pkg::policy_t   pol_wr,
	output dapc_pkg::counters_t cnt_wr,
	output logic [63:0]         violation_total,
	output logic [63:0]         check_total
);
	import dapc_pkg::*;

	logic      oob;
	logic      known;
	logic      win;
	caps_t     caps_base;
	caps_t     caps_masked;
	policy_t   pol;
	counters_t cnt;
	logic      in_range;
	logic      deny;

	assign oob   = {1'b0, req.slot_id} >= 9'(DRIVER_SLOTS);
	assign known = {1'b0, req.slot_id} < count;

	assign pol = entry_valid ? pol_rd : '0;
	assign cnt = entry_valid ? cnt_rd : '0;

	// new entry on register
	assign caps_base   = class_defaults(req.device_class_major);
	assign caps_masked = (req.claimed_caps != 16'd0) ? (caps_base & req.claimed_caps[6:0])
	                                                  : caps_base;
	assign win         = (req.win_base != 64'd0) && (req.win_size != 64'd0);

	always_comb begin
		pol_wr.caps         = caps_masked & closure(req.claimed_caps[6:0]);
		pol_wr.mmio_present = win;
		pol_wr.mmio_low     = win ? req.win_base : 64'd0;
		pol_wr.mmio_high    = win ? (req.win_base + req.win_size - 64'd1) : 64'd0;
		pol_wr.irq_present  = req.irq_number != 32'd0;
		pol_wr.irq_line     = req.irq_number;
		pol_wr.dma_present  = win && ((caps_masked & CAP_DMA) != '0);
	end

	// window match for a check
	always_comb begin
		unique case (req.access_kind)
			KIND_MMIO: in_range = pol.mmio_present && (req.address >= pol.mmio_low)
			                      && (req.address <= pol.mmio_high);
			KIND_DMA:  in_range = pol.dma_present && (req.address >= pol.mmio_low)
			                      && (req.address <= pol.mmio_high);
			KIND_IRQ:  in_range = pol.irq_present && (req.address == {32'd0, pol.irq_line});
			default:   in_range = 1'b0;
		endcase
	end

	assign deny = ((pol.caps & req.required_caps[6:0]) == '0) || !in_range;

	always_comb begin
		verdict         = '0;
		verdict.status  = ST_OK;
		cnt_wr          = '0;
		violation_total = 64'd0;
		check_total     = 64'd0;
		if (oob) begin
			verdict.status = ST_RANGE;
		end else begin
			unique case (req.command)
				CMD_REGISTER: begin
					verdict.policy_we   = 1'b1;
					verdict.counters_we = 1'b1;
					verdict.count_inc   = 1'b1;
				end
				CMD_CHECK: begin
					if (!known) begin
						verdict.status = ST_DENIED;
					end else begin
						verdict.counters_we = 1'b1;
						cnt_wr.chk          = cnt.chk + 64'd1;
						cnt_wr.viol         = cnt.viol + {63'd0, deny};
						verdict.status      = deny ? ST_DENIED : ST_OK;
					end
				end
				CMD_QUERY: begin
					if (!known) begin
						verdict.status  = ST_DENIED;
						violation_total = '1;
						check_total     = '1;
					end else begin
						violation_total = cnt.viol;
						check_total     = cnt.chk;
					end
				end
				default: begin
					verdict.status = ST_DENIED;
				end
			endcase
		end
	end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the driver access policy checker
// ----------------------------------------------------------------------------
// A table of directed request beats (reset state, slot range errors, the unused
// command, window edges, wrapped windows, irq lines, capability misses) runs
// first, then random traffic of every command that aims its addresses at the
// stored windows and irq lines. Every response beat is checked against its
// table row or an in-bench policy table model. Both channels idle and stall
// at random, with stretches of back-to-back traffic and drain points between.
// ----------------------------------------------------------------------------
module tb;
	import dapc_pkg::*;

	localparam int SLOTS        = 64;
	localparam int RANDOM_BEATS = 1750;
	localparam int BLOCK        = 250;
	localparam int STALL_LIMIT  = 500;

	localparam logic [1:0]  CMD_UNUSED = 2'd3;
	localparam logic [63:0] ALL_ONES   = '1;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] viol;
		logic [63:0] chk;
	} answer_t;

	typedef struct {
		request_t req;
		bit       typed;
		answer_t  want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	dapc_req_if req_ch ();
	dapc_rsp_if rsp_ch ();

	driver_access_policy_checker_core #(
		.DRIVER_SLOTS(SLOTS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	policy_t   policy_tab  [SLOTS];
	counters_t counter_tab [SLOTS];
	logic [8:0] drivers_seen;

	answer_t pending_answers [$];
	row_t    directed_rows [$];

	bit gaps_on = 1'b1;
	int mismatches = 0;
	int idle_cycles = 0;
	int n_beats = 0, n_reg = 0, n_chk = 0, n_grant = 0, n_qry = 0, n_range = 0;

	function automatic caps_t caps_for_class(input logic [15:0] major);
		case (major)
			16'd1: return CAP_OBS | CAP_CTL | CAP_DMA | CAP_FW;
			16'd2, 16'd3, 16'd5: return CAP_OBS | CAP_CTL | CAP_INT | CAP_DMA;
			16'd4: return CAP_OBS | CAP_CTL | CAP_INT | CAP_DMA | CAP_PWR;
			16'd6: return CAP_OBS | CAP_INT;
			16'd7: return CAP_OBS | CAP_CTL;
			16'd8: return CAP_OBS | CAP_PWR;
			default: return CAP_OBS;
		endcase
	endfunction

	// clip mask by one plus the index of the top declared bit
	function automatic caps_t clip_for(input int top);
		case (top)
			0: return '0;
			1: return CAP_OBS;
			2: return CAP_OBS | CAP_CTL;
			3: return CAP_OBS | CAP_CTL | CAP_INT;
			4: return CAP_OBS | CAP_CTL | CAP_DMA;
			5: return CAP_OBS | CAP_CTL | CAP_INT | CAP_DMA | CAP_PWR;
			6: return CAP_OBS | CAP_CTL | CAP_INT | CAP_DMA | CAP_PWR | CAP_FW;
			default: return CAP_ALL;
		endcase
	endfunction

	// updates the policy table and returns the response the beat must produce
	function automatic answer_t judge_request(input request_t r);
		answer_t a;
		caps_t   caps;
		policy_t p;
		logic    win;
		logic    hit;
		int      top;
		int      i;
		int      d;
		a = '0;
		n_beats++;
		if (r.slot_id >= SLOTS) begin
			a.status = ST_RANGE;
			n_range++;
			return a;
		end
		d = int'(r.slot_id);
		case (r.command)
			CMD_REGISTER: begin
				caps = caps_for_class(r.device_class_major);
				if (r.claimed_caps != 16'd0) caps = caps & r.claimed_caps[6:0];
				win = (r.win_base != 64'd0) && (r.win_size != 64'd0);
				p.mmio_present = win;
				p.mmio_low = win ? r.win_base : 64'd0;
				p.mmio_high = win ? r.win_base + r.win_size - 64'd1 : 64'd0;
				p.irq_present = (r.irq_number != 32'd0);
				p.irq_line = r.irq_number;
				p.dma_present = win && ((caps & CAP_DMA) != '0);
				top = 0;
				for (i = 0; i < 7; i++) begin
					if (r.claimed_caps[i]) top = i + 1;
				end
				p.caps = caps & clip_for(top);
				policy_tab[d] = p;
				counter_tab[d] = '0;
				if (drivers_seen != COUNT_MAX) drivers_seen = drivers_seen + 9'd1;
				n_reg++;
			end
			CMD_CHECK: begin
				n_chk++;
				if ({1'b0, r.slot_id} >= drivers_seen) begin
					a.status = ST_DENIED;
				end else begin
					p = policy_tab[d];
					counter_tab[d].chk = counter_tab[d].chk + 64'd1;
					case (r.access_kind)
						KIND_MMIO: hit = p.mmio_present && r.address >= p.mmio_low &&
							r.address <= p.mmio_high;
						KIND_DMA: hit = p.dma_present && r.address >= p.mmio_low &&
							r.address <= p.mmio_high;
						KIND_IRQ: hit = p.irq_present && r.address == {32'd0, p.irq_line};
						default: hit = 1'b0;
					endcase
					if ((p.caps & r.required_caps[6:0]) == '0 || !hit) begin
						counter_tab[d].viol = counter_tab[d].viol + 64'd1;
						a.status = ST_DENIED;
					end else begin
						n_grant++;
					end
				end
			end
			CMD_QUERY: begin
				n_qry++;
				if ({1'b0, r.slot_id} >= drivers_seen) begin
					a.status = ST_DENIED;
					a.viol = ALL_ONES;
					a.chk = ALL_ONES;
				end else begin
					a.viol = counter_tab[d].viol;
					a.chk = counter_tab[d].chk;
				end
			end
			default: a.status = ST_DENIED;
		endcase
		return a;
	endfunction

	function automatic request_t beat_of(input logic [1:0] cmd, input logic [7:0] id,
		input logic [7:0] kind, input logic [63:0] addr, input logic [15:0] caps,
		input logic [15:0] major, input logic [15:0] decl, input logic [63:0] base,
		input logic [63:0] size, input logic [31:0] irq);
		request_t r;
		r.command = cmd;
		r.slot_id = id;
		r.access_kind = kind;
		r.address = addr;
		r.required_caps = caps;
		r.device_class_major = major;
		r.claimed_caps = decl;
		r.win_base = base;
		r.win_size = size;
		r.irq_number = irq;
		return r;
	endfunction

	function automatic void add_row(input request_t r, input logic [1:0] st,
		input logic [63:0] viol, input logic [63:0] chk);
		row_t row;
		row.req = r;
		row.typed = 1'b1;
		row.want = '{status: st, viol: viol, chk: chk};
		directed_rows.push_back(row);
	endfunction

	function automatic void add_pred(input request_t r);
		row_t row;
		row.req = r;
		row.typed = 1'b0;
		row.want = '0;
		directed_rows.push_back(row);
	endfunction

	function automatic request_t random_request();
		request_t r;
		policy_t  p;
		int       pick;
		logic [63:0] lo, hi;
		r = beat_of(2'($urandom), 8'($urandom), 8'($urandom), {$urandom, $urandom},
			16'($urandom), 16'($urandom), 16'($urandom), {$urandom, $urandom},
			{$urandom, $urandom}, $urandom);
		pick = $urandom_range(0, 99);
		r.command = (pick < 25) ? CMD_REGISTER : (pick < 75) ? CMD_CHECK :
			(pick < 93) ? CMD_QUERY : CMD_UNUSED;
		pick = $urandom_range(0, 99);
		if (pick < 60) r.slot_id = 8'($urandom_range(0, 15));
		else if (pick < 90) r.slot_id = 8'($urandom_range(0, SLOTS - 1));
		else r.slot_id = 8'($urandom_range(SLOTS, 255));

		if (r.command == CMD_REGISTER) begin
			if ($urandom_range(0, 9) < 7) r.device_class_major = 16'($urandom_range(0, 9));
			pick = $urandom_range(0, 99);
			if (pick < 25) r.claimed_caps = '0;
			else if (pick < 70) r.claimed_caps = 16'($urandom_range(1, 127));
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				r.win_base = '0;
			end else if (pick < 20) begin
				r.win_size = '0;
			end else if (pick < 30) begin
				r.win_base = ALL_ONES - 64'($urandom_range(0, 255));
				r.win_size = 64'($urandom_range(1, 1024));
			end else if (pick < 65) begin
				r.win_size = 64'($urandom_range(1, 65536));
			end
			pick = $urandom_range(0, 99);
			if (pick < 20) r.irq_number = '0;
			else if (pick < 70) r.irq_number = 32'($urandom_range(1, 64));
		end else if (r.command == CMD_CHECK) begin
			if ($urandom_range(0, 99) < 85) r.access_kind = 8'($urandom_range(1, 3));
			pick = $urandom_range(0, 99);
			if (pick < 50) r.required_caps = 16'd1 << $urandom_range(0, 6);
			else if (pick < 75) r.required_caps = 16'($urandom_range(1, 127));
			else if (pick < 92 && pick >= 85) r.required_caps = {r.required_caps[15:7], 7'd0};
			else if (pick >= 92) r.required_caps = 16'hFFFF;
			p = policy_tab[(r.slot_id < SLOTS) ? r.slot_id : 0];
			lo = p.mmio_low;
			hi = p.mmio_high;
			if ($urandom_range(0, 99) >= 20) begin
				if (r.access_kind == KIND_IRQ) begin
					case ($urandom_range(0, 3))
						0: r.address = {32'd0, p.irq_line} + 64'd1;
						1: r.address = {32'd0, p.irq_line} - 64'd1;
						default: r.address = {32'd0, p.irq_line};
					endcase
				end else begin
					case ($urandom_range(0, 5))
						0: r.address = lo;
						1: r.address = hi;
						2: r.address = lo - 64'd1;
						3: r.address = hi + 64'd1;
						default: r.address = (hi >= lo) ?
							lo + ((hi - lo) >> $urandom_range(1, 8)) : lo;
					endcase
				end
			end
		end
		return r;
	endfunction

	task automatic drive_payload(input request_t r);
		req_ch.command <= r.command;
		req_ch.slot_id <= r.slot_id;
		req_ch.access_kind <= r.access_kind;
		req_ch.address <= r.address;
		req_ch.required_caps <= r.required_caps;
		req_ch.device_class_major <= r.device_class_major;
		req_ch.claimed_caps <= r.claimed_caps;
		req_ch.win_base <= r.win_base;
		req_ch.win_size <= r.win_size;
		req_ch.irq_number <= r.irq_number;
	endtask

	task automatic send_beat(input request_t r, input bit typed, input answer_t want);
		int gap;
		answer_t predicted;
		gap = gaps_on ? $urandom_range(0, 5) : 0;
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		drive_payload(r);
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		predicted = judge_request(r);
		pending_answers.push_back(typed ? want : predicted);
	endtask

	task automatic hold_until_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_answers.size() != 0);
	endtask

	// response side
	initial begin
		int stall;
		answer_t want;
		forever begin
			stall = gaps_on ? $urandom_range(0, 5) : 0;
			if (stall != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid === 1'b1 && arst_n === 1'b1));
			if (pending_answers.size() == 0) begin
				$error("response beat with nothing expected, status %0d", rsp_ch.status);
				mismatches++;
			end else begin
				want = pending_answers.pop_front();
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
					mismatches++;
				end
				if (rsp_ch.violation_total !== want.viol) begin
					$error("violation_total: expected %h, actual %h", want.viol,
						rsp_ch.violation_total);
					mismatches++;
				end
				if (rsp_ch.check_total !== want.chk) begin
					$error("check_total: expected %h, actual %h", want.chk,
						rsp_ch.check_total);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
			(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// request side
	initial begin
		int n;
		arst_n = 1'b0;
		req_ch.valid <= 1'b0;
		drive_payload('0);
		drivers_seen = '0;
		foreach (policy_tab[i]) begin
			policy_tab[i] = '0;
			counter_tab[i] = '0;
		end

		// unknown slots after reset, range errors, unused command
		add_row(beat_of(CMD_QUERY, 8'd0, 8'd0, 64'd0, 16'd0, 16'd0, 16'd0, 64'd0, 64'd0, 32'd0),
			ST_DENIED, ALL_ONES, ALL_ONES);
		add_row(beat_of(CMD_CHECK, 8'd0, KIND_MMIO, 64'd0, 16'hFFFF, 16'd0, 16'd0, 64'd0, 64'd0,
			32'd0), ST_DENIED, 64'd0, 64'd0);
		add_row(beat_of(CMD_REGISTER, 8'd64, 8'd0, 64'd0, 16'd0, 16'd1, 16'd0, 64'h10, 64'h10,
			32'd1), ST_RANGE, 64'd0, 64'd0);
		add_row(beat_of(CMD_QUERY, 8'd255, 8'd0, 64'd0, 16'd0, 16'd0, 16'd0, 64'd0, 64'd0, 32'd0),
			ST_RANGE, 64'd0, 64'd0);
		add_row(beat_of(CMD_UNUSED, 8'd0, 8'd0, 64'd0, 16'd0, 16'd0, 16'd0, 64'd0, 64'd0, 32'd0),
			ST_DENIED, 64'd0, 64'd0);
		// window edges on a class 1 driver
		add_row(beat_of(CMD_REGISTER, 8'd0, 8'd0, 64'd0, 16'd0, 16'd1, 16'd0, 64'h1000, 64'h100,
			32'd5), ST_OK, 64'd0, 64'd0);
		add_pred(beat_of(CMD_CHECK, 8'd0, KIND_MMIO, 64'h1000, 16'h2, 16'd0, 16'd0, 64'd0, 64'd0,
			32'd0));
		add_pred(beat_of(CMD_CHECK, 8'd0, KIND_MMIO, 64'h10FF, 16'h2, 16'd0, 16'd0, 64'd0, 64'd0,
			32'd0));
		add_pred(beat_of(CMD_CHECK, 8'd0, KIND_MMIO, 64'h1100, 16'h2, 16'd0, 16'd0, 64'd0, 64'd0,
			32'd0));
		add_pred(beat_of(CMD_CHECK, 8'd0, KIND_DMA, 64'h0FFF, 16'h8, 16'd0, 16'd0, 64'd0, 64'd0,
			32'd0));
		add_pred(beat_of(CMD_CHECK, 8'd0, KIND_DMA, 64'h1080, 16'h8, 16'd0, 16'd0, 64'd0, 64'd0,
			32'd0));
		add_pred(beat_of(CMD_CHECK, 8'd0, KIND_IRQ, 64'd5, 16'h4, 16'd0, 16'd0, 64'd0, 64'd0,
			32'd0));
		add_pred(beat_of(CMD_CHECK, 8'd0, 8'd0, 64'h1000, 16'h1, 16'd0, 16'd0, 64'd0, 64'd0,
			32'd0));
		add_pred(beat_of(CMD_CHECK, 8'd0, 8'd255, ALL_ONES, 16'hFFFF, 16'd0, 16'd0, 64'd0, 64'd0,
			32'd0));
		add_pred(beat_of(CMD_CHECK, 8'd0, KIND_MMIO, 64'h1000, 16'hFF80, 16'd0, 16'd0, 64'd0,
			64'd0, 32'd0));
		// wrapped window, top irq line
		add_row(beat_of(CMD_REGISTER, 8'd1, 8'd0, 64'd0, 16'd0, 16'd4, 16'hFFFF,
			64'hFFFF_FFFF_FFFF_FF00, 64'h200, 32'hFFFF_FFFF), ST_OK, 64'd0, 64'd0);
		add_pred(beat_of(CMD_CHECK, 8'd1, KIND_MMIO, 64'hFFFF_FFFF_FFFF_FF80, 16'h1, 16'd0,
			16'd0, 64'd0, 64'd0, 32'd0));
		add_pred(beat_of(CMD_CHECK, 8'd1, KIND_IRQ, 64'hFFFF_FFFF, 16'h4, 16'd0, 16'd0, 64'd0,
			64'd0, 32'd0));
		// last slot, registered but above the driver count
		add_row(beat_of(CMD_REGISTER, 8'd63, 8'd0, 64'd0, 16'd0, 16'hFFFF, 16'h0001, ALL_ONES,
			64'd1, 32'd0), ST_OK, 64'd0, 64'd0);
		add_row(beat_of(CMD_CHECK, 8'd63, KIND_MMIO, ALL_ONES, 16'h1, 16'd0, 16'd0, 64'd0, 64'd0,
			32'd0), ST_DENIED, 64'd0, 64'd0);
		add_row(beat_of(CMD_REGISTER, 8'd2, 8'd0, 64'd0, 16'd0, 16'd6, 16'h0040, 64'd0, 64'd5,
			32'd1), ST_OK, 64'd0, 64'd0);
		add_pred(beat_of(CMD_QUERY, 8'd0, 8'd0, 64'd0, 16'd0, 16'd0, 16'd0, 64'd0, 64'd0, 32'd0));
		add_pred(beat_of(CMD_QUERY, 8'd1, 8'd0, 64'd0, 16'd0, 16'd0, 16'd0, 64'd0, 64'd0, 32'd0));
		add_pred(beat_of(CMD_CHECK, 8'd2, KIND_IRQ, 64'd1, 16'h4, 16'd0, 16'd0, 64'd0, 64'd0,
			32'd0));
		// re-register clears counters, window reaching the top address
		add_row(beat_of(CMD_REGISTER, 8'd0, 8'd0, 64'd0, 16'd0, 16'd8, 16'd0, 64'd1, ALL_ONES,
			32'd0), ST_OK, 64'd0, 64'd0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_beat(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
		hold_until_drained();

		for (n = 0; n < RANDOM_BEATS; n++) begin
			if (n != 0 && n % BLOCK == 0) begin
				hold_until_drained();
				gaps_on = ((n / BLOCK) % 2) == 0;
			end
			send_beat(random_request(), 1'b0, '0);
		end
		hold_until_drained();
		repeat (8) @(posedge clk);

		$display("%0d request beats: %0d registrations, %0d checks (%0d granted), %0d counter reads",
			n_beats, n_reg, n_chk, n_grant, n_qry);
		$display("%0d beats hit a slot beyond the table; driver count ended at %0d",
			n_range, drivers_seen);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
